/* rtl/npdh_pkg.sv */
// ----------------------------------------------------------------------------
// npdh_pkg
// Shared types and constants for the nearest point heading block: control
// structs between modules, CORDIC angle table and fixed-point limits.
// ----------------------------------------------------------------------------
package npdh_pkg;

	localparam int TAB_LEN = 24;
	localparam int IDX_W   = 5;
	localparam int XW      = 64;
	localparam int ZW      = 36;
	localparam int HW      = ZW - 17;

	localparam logic signed [ZW-1:0] PI_Q30   = 36'sd3373259426;
	localparam logic signed [ZW-1:0] ROUND_Q30 = 36'sd65536;
	localparam logic signed [15:0]   PI_Q13   = 16'sd25736;
	localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [HW-1:0] H_MAX    = 19'sd25736;
	localparam logic signed [HW-1:0] H_MIN    = -19'sd25736;

	typedef struct packed {
		logic fin_valid;
		logic last_pend;
	} npdh_scan_t;

	typedef struct packed {
		logic trivial;
	} npdh_stat_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} npdh_cmd_t;

	function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:    v = 32'h3243F6A8;
			5'd1:    v = 32'h1DAC6705;
			5'd2:    v = 32'h0FADBAFC;
			5'd3:    v = 32'h07F56EA6;
			5'd4:    v = 32'h03FEAB76;
			5'd5:    v = 32'h01FFD55B;
			5'd6:    v = 32'h00FFFAAA;
			5'd7:    v = 32'h007FFF55;
			5'd8:    v = 32'h003FFFEA;
			5'd9:    v = 32'h001FFFFD;
			5'd10:   v = 32'h000FFFFF;
			5'd11:   v = 32'h0007FFFF;
			5'd12:   v = 32'h0003FFFF;
			5'd13:   v = 32'h0001FFFF;
			5'd14:   v = 32'h0000FFFF;
			5'd15:   v = 32'h00007FFF;
			5'd16:   v = 32'h00003FFF;
			5'd17:   v = 32'h00001FFF;
			5'd18:   v = 32'h00000FFF;
			5'd19:   v = 32'h000007FF;
			5'd20:   v = 32'h000003FF;
			5'd21:   v = 32'h000001FF;
			5'd22:   v = 32'h000000FF;
			5'd23:   v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* rtl/npdh_scan.sv */
// ----------------------------------------------------------------------------
// npdh_scan
// Candidate scan pipeline: offsets and magnitudes, squares, then squared
// distance compare against the running best. Hands the winner to the
// heading engine on the last transaction of a scan and clears itself.
// ----------------------------------------------------------------------------
module npdh_scan import npdh_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [15:0]             observer_x,
	input  logic [15:0]             observer_y,
	input  logic [15:0]             point_x,
	input  logic [15:0]             point_y,
	input  logic                    point_present,
	input  logic                    last_point,
	output npdh_scan_t              sts,
	output logic signed [COORD_BITS:0] fin_dx,
	output logic signed [COORD_BITS:0] fin_dy,
	output logic                    fin_found
);

	localparam int CB = COORD_BITS;
	localparam int UB = (CB < 16) ? CB : 16;
	localparam int SW = 2 * CB;
	localparam int BW = 2 * CB + 2;
	localparam logic [BW-1:0] SAT_MAX = (BW > 64) ? BW'({64{1'b1}}) : {BW{1'b1}};

	logic [CB-1:0] ox, oy, px, py;
	logic signed [CB:0] dx, dy;
	logic [CB-1:0] mx, my;

	logic v_s1, last_s1, pres_s1;
	logic signed [CB:0] dx_s1, dy_s1;
	logic [CB-1:0] mx_s1, my_s1;

	logic v_s2, last_s2, pres_s2;
	logic signed [CB:0] dx_s2, dy_s2;
	logic [SW-1:0] sx_s2, sy_s2;

	logic [BW-1:0] best_q;
	logic signed [CB:0] bx_q, by_q;
	logic found_q;

	logic [SW-1:0] sqx, sqy;
	logic [BW-1:0] sum, d2;
	logic take;

	assign ox = CB'(observer_x[UB-1:0]);
	assign oy = CB'(observer_y[UB-1:0]);
	assign px = CB'(point_x[UB-1:0]);
	assign py = CB'(point_y[UB-1:0]);

	assign dx = $signed({1'b0, ox}) - $signed({1'b0, px});
	assign dy = $signed({1'b0, oy}) - $signed({1'b0, py});
	assign mx = CB'(dx[CB] ? -dx : dx);
	assign my = CB'(dy[CB] ? -dy : dy);

	assign sqx = {{CB{1'b0}}, mx_s1} * {{CB{1'b0}}, mx_s1};
	assign sqy = {{CB{1'b0}}, my_s1} * {{CB{1'b0}}, my_s1};

	assign sum  = BW'(sx_s2) + BW'(sy_s2);
	assign d2   = (sum > SAT_MAX) ? SAT_MAX : sum;
	assign take = v_s2 && pres_s2 && (!found_q || (d2 < best_q));

	assign fin_dx    = take ? dx_s2 : bx_q;
	assign fin_dy    = take ? dy_s2 : by_q;
	assign fin_found = found_q || take;

	assign sts.fin_valid = v_s2 && last_s2;
	assign sts.last_pend = (v_s1 && last_s1) || (v_s2 && last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= accept;
			last_s1 <= last_point;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		pres_s1 <= point_present;
		dx_s1   <= dx;
		dy_s1   <= dy;
		mx_s1   <= mx;
		my_s1   <= my;
		pres_s2 <= pres_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		sx_s2   <= sqx;
		sy_s2   <= sqy;
	end

	// running best, cleared at the end of each scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= {BW{1'b1}};
			bx_q    <= '0;
			by_q    <= '0;
			found_q <= 1'b0;
		end else if (v_s2 && last_s2) begin
			best_q  <= {BW{1'b1}};
			bx_q    <= '0;
			by_q    <= '0;
			found_q <= 1'b0;
		end else if (take) begin
			best_q  <= d2;
			bx_q    <= dx_s2;
			by_q    <= dy_s2;
			found_q <= 1'b1;
		end
	end

endmodule

/* rtl/npdh_cordic.sv */
// ----------------------------------------------------------------------------
// npdh_cordic
// Heading datapath: vectoring CORDIC, one iteration per step command, with
// direct results for the axis and empty cases and the output register.
// ----------------------------------------------------------------------------
module npdh_cordic import npdh_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  npdh_cmd_t                  cmd,
	input  logic signed [COORD_BITS:0] fin_dx,
	input  logic signed [COORD_BITS:0] fin_dy,
	input  logic                       fin_found,
	output npdh_stat_t                 stat,
	output logic signed [15:0]         heading,
	output logic                       found
);

	localparam int CB = COORD_BITS;
	localparam int SH = 60 - CB;

	logic dx_neg, dy_neg, dx_zero, dy_zero;
	logic [CB-1:0] mag_x, mag_y;
	logic signed [XW-1:0] x_init, y_mag, y_init;
	logic signed [ZW-1:0] z_init;
	logic signed [15:0] triv_h;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic spec_q, fnd_q;
	logic signed [15:0] spec_h_q;
	logic signed [15:0] heading_q;
	logic found_q;

	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	logic y_pos;
	logic signed [ZW-1:0] zr;
	logic signed [HW-1:0] hq;
	logic signed [15:0] h_clamp;

	assign dx_neg  = fin_dx[CB];
	assign dy_neg  = fin_dy[CB];
	assign dx_zero = (fin_dx == '0);
	assign dy_zero = (fin_dy == '0);
	assign mag_x   = CB'(dx_neg ? -fin_dx : fin_dx);
	assign mag_y   = CB'(dy_neg ? -fin_dy : fin_dy);

	assign x_init = $signed(XW'(mag_x) << SH);
	assign y_mag  = $signed(XW'(mag_y) << SH);
	assign y_init = (dx_neg ^ dy_neg) ? -y_mag : y_mag;
	assign z_init = dx_neg ? (dy_neg ? -PI_Q30 : PI_Q30) : '0;

	assign stat.trivial = !fin_found || dx_zero || dy_zero;

	always_comb begin
		if (!fin_found || (dx_zero && dy_zero)) begin
			triv_h = '0;
		end else if (dy_zero) begin
			triv_h = dx_neg ? PI_Q13 : '0;
		end else begin
			triv_h = dy_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
		end
	end

	assign xs    = x_q >>> cmd.idx;
	assign ys    = y_q >>> cmd.idx;
	assign at    = $signed(ZW'(atan_q30(cmd.idx)));
	assign y_pos = !y_q[XW-1] && (y_q != '0);

	// round half up to q3.13, then limit to +-pi
	assign zr = z_q + ROUND_Q30;
	assign hq = zr[ZW-1:17];

	always_comb begin
		if (hq > H_MAX) begin
			h_clamp = PI_Q13;
		end else if (hq < H_MIN) begin
			h_clamp = -PI_Q13;
		end else begin
			h_clamp = 16'(hq);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x_init;
			y_q      <= y_init;
			z_q      <= z_init;
			spec_q   <= stat.trivial;
			spec_h_q <= triv_h;
			fnd_q    <= fin_found;
		end else if (cmd.step) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			found_q   <= 1'b0;
		end else if (cmd.emit) begin
			heading_q <= spec_q ? spec_h_q : h_clamp;
			found_q   <= fnd_q;
		end
	end

	assign heading = heading_q;
	assign found   = found_q;

endmodule

/* rtl/npdh_ctrl.sv */
// ----------------------------------------------------------------------------
// npdh_ctrl
// Controller: starts the heading engine on the end of a scan, counts CORDIC
// iterations, owns the output valid and the input stall.
// ----------------------------------------------------------------------------
module npdh_ctrl import npdh_pkg::*; #(
	parameter int NSTEP = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  npdh_scan_t scan,
	input  npdh_stat_t stat,
	input  logic       last_point,
	input  logic       out_stall,
	output logic       in_stall,
	output logic       out_valid,
	output npdh_cmd_t  cmd
);

	localparam int CW = $clog2(NSTEP);
	localparam logic [CW-1:0] CNT_LAST = CW'(NSTEP - 1);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && scan.fin_valid;
		cmd.step = (state_q == S_RUN);
		cmd.emit = (state_q == S_WAIT) && (!out_valid_q || !out_stall);
		cmd.idx  = IDX_W'(cnt_q);
	end

	// only the closing transaction of a scan waits for the engine
	assign in_stall  = last_point && ((state_q != S_IDLE) || scan.last_pend);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						cnt_q   <= '0;
						state_q <= stat.trivial ? S_WAIT : S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan.fin_valid |-> state_q == S_IDLE)
		else $error("scan finished while heading engine busy");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a pending output");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_WAIT)
		else $error("output valid raised outside result hand-off");

endmodule

/* rtl/nearest_point_heading.sv */
// ----------------------------------------------------------------------------
// nearest_point_heading
// Nearest candidate search with atan2 heading of the winning offset.
//
// Input channel (in_valid / in_stall): one candidate per transaction with
// the observer position; last_point closes a scan. Candidates with
// point_present low are skipped but still close a scan when marked last.
// Output channel (out_valid / out_stall): one transaction per scan with
// heading (Q3.13 radians) and found.
// Throughput: one candidate per cycle. Only a last_point transaction can be
// stalled, while the previous scan's heading is still being computed or
// its result waits in the output register together with a new result.
// From the last candidate, the result passes the s1 and s2 scan registers, the
// CORDIC load and, unless no candidate was found or the offset lies on an axis,
// the CORDIC unit doing one iteration per cycle, then the emit to out_valid.
// The output register holds its result while out_stall is high; the next
// scan runs meanwhile. Reset clears the scan state and the output valid.
// ----------------------------------------------------------------------------
module nearest_point_heading import npdh_pkg::*; #(
	parameter int COORD_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        observer_x,
	input  logic [15:0]        observer_y,
	input  logic [15:0]        point_x,
	input  logic [15:0]        point_y,
	input  logic               point_present,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] heading,
	output logic               found
);

	localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	npdh_scan_t scan;
	npdh_stat_t stat;
	npdh_cmd_t  cmd;
	logic signed [COORD_BITS:0] fin_dx, fin_dy;
	logic fin_found;
	logic accept;

	assign accept = in_valid && !in_stall;

	npdh_scan #(
		.COORD_BITS(COORD_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.observer_x   (observer_x),
		.observer_y   (observer_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_present(point_present),
		.last_point   (last_point),
		.sts          (scan),
		.fin_dx       (fin_dx),
		.fin_dy       (fin_dy),
		.fin_found    (fin_found)
	);

	npdh_cordic #(
		.COORD_BITS(COORD_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.fin_dx   (fin_dx),
		.fin_dy   (fin_dy),
		.fin_found(fin_found),
		.stat     (stat),
		.heading  (heading),
		.found    (found)
	);

	npdh_ctrl #(
		.NSTEP(NSTEP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan      (scan),
		.stat      (stat),
		.last_point(last_point),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

endmodule

/* verif/tb_nearest_point_heading.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_point_heading
// Self-checking bench for the nearest point heading block. A directed table
// covers empty scans, zero and axis offsets, extreme coordinates, ties and
// absent closing candidates. Random scans with near, axis-aligned and tied
// candidates follow. Every closing transaction is scored: typed directed rows
// against their table result, the rest against an in-bench nearest-search and
// CORDIC atan2 predictor. Bursty input traffic, patterned output backpressure,
// one long output hold and full drains exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_nearest_point_heading;

	localparam int COORD_W       = 16;
	localparam int CORDIC_ITERS  = 16;
	localparam int PRE_SHIFT     = 60 - COORD_W;
	localparam int RANDOM_ITEMS  = 950;
	localparam int HOLD_CYCLES   = 400;
	localparam logic signed [15:0] HDG_PI      = 16'sd25736;
	localparam logic signed [15:0] HDG_HALF_PI = 16'sd12868;
	localparam longint ANGLE_PI   = 64'sd3373259426;

	typedef struct packed {
		logic signed [15:0] heading;
		logic               found;
	} scan_result_t;

	typedef struct packed {
		logic [15:0]        ox;
		logic [15:0]        oy;
		logic [15:0]        px;
		logic [15:0]        py;
		bit                 pres;
		bit                 lst;
		bit                 typed;
		logic signed [15:0] exp_heading;
		bit                 exp_found;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        observer_x;
	logic [15:0]        observer_y;
	logic [15:0]        point_x;
	logic [15:0]        point_y;
	logic               point_present;
	logic               last_point;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] heading;
	logic               found;

	longint       atan_z [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	// running scan state of the predictor
	longint       near_d2;
	longint       near_dx;
	longint       near_dy;
	bit           near_valid;

	scan_result_t expected_headings [$];
	scan_result_t head_result;
	stim_row_t    directed_rows [0:23];
	int           mismatches = 0;
	int           items_sent = 0;
	int           burst_left = 0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int           stall_mode = 0;
	int           mode_left = 0;

	always #6 clk = ~clk;

	nearest_point_heading #(
		.COORD_BITS  (COORD_W),
		.CORDIC_STEPS(CORDIC_ITERS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.observer_x   (observer_x),
		.observer_y   (observer_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_present(point_present),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heading      (heading),
		.found        (found)
	);

	function automatic logic signed [15:0] cordic_atan2(input longint dx, input longint dy);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		longint h;
		if (dx == 0 && dy == 0)
			return 16'sd0;
		if (dy == 0)
			return (dx > 0) ? 16'sd0 : HDG_PI;
		if (dx == 0)
			return (dy > 0) ? HDG_HALF_PI : -HDG_HALF_PI;
		x = ((dx < 0) ? -dx : dx) <<< PRE_SHIFT;
		y = ((dy < 0) ? -dy : dy) <<< PRE_SHIFT;
		if (dy < 0)
			y = -y;
		z = 0;
		// left half plane: rotate by pi first
		if (dx < 0) begin
			y = -y;
			z = (dy > 0) ? ANGLE_PI : -ANGLE_PI;
		end
		for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_z[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_z[i];
			end
		end
		h = (z + 64'sd65536) >>> 17;
		if (h > longint'(HDG_PI))
			h = longint'(HDG_PI);
		if (h < -longint'(HDG_PI))
			h = -longint'(HDG_PI);
		return h[15:0];
	endfunction

	function automatic void clear_scan();
		near_d2 = 64'h7FFF_FFFF_FFFF_FFFF;
		near_dx = 0;
		near_dy = 0;
		near_valid = 1'b0;
	endfunction

	function automatic bit fold_candidate(input logic [15:0] ox, input logic [15:0] oy,
			input logic [15:0] px, input logic [15:0] py, input bit pres, input bit lst,
			output scan_result_t res);
		longint dx;
		longint dy;
		longint d2;
		res = '0;
		if (pres) begin
			dx = longint'(ox) - longint'(px);
			dy = longint'(oy) - longint'(py);
			d2 = dx * dx + dy * dy;
			if (!near_valid || d2 < near_d2) begin
				near_d2 = d2;
				near_dx = dx;
				near_dy = dy;
				near_valid = 1'b1;
			end
		end
		if (!lst)
			return 1'b0;
		if (near_valid) begin
			res.heading = cordic_atan2(near_dx, near_dy);
			res.found = 1'b1;
		end
		clear_scan();
		return 1'b1;
	endfunction

	task automatic offer(input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] px,
			input logic [15:0] py, input bit pres, input bit lst, input bit typed,
			input scan_result_t typed_res);
		scan_result_t res;
		observer_x <= ox;
		observer_y <= oy;
		point_x <= px;
		point_y <= py;
		point_present <= pres;
		last_point <= lst;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (fold_candidate(ox, oy, px, py, pres, lst, res))
			expected_headings.push_back(typed ? typed_res : res);
	endtask

	// bursts of transactions separated by random gaps
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 16);
		end
	endtask

	task automatic drain_outputs();
		if (in_valid)
			in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_headings.size() != 0);
	endtask

	task automatic random_scan();
		int          len;
		int          kind;
		int          radius;
		bit          all_absent;
		bit          pres;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] lpx;
		logic [15:0] lpy;
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
		all_absent = ($urandom_range(0, 29) == 0);
		ox = 16'($urandom);
		oy = 16'($urandom);
		lpx = 16'($urandom);
		lpy = 16'($urandom);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 6) == 0) begin
				ox = 16'($urandom);
				oy = 16'($urandom);
			end
			kind = $urandom_range(0, 9);
			radius = ($urandom_range(0, 1) == 0) ? 63 : 1023;
			case (kind) inside
				[3:5]: begin
					px = ox + 16'($urandom_range(0, 2 * radius)) - 16'(radius);
					py = oy + 16'($urandom_range(0, 2 * radius)) - 16'(radius);
				end
				6: begin
					px = 16'($urandom);
					py = oy;
				end
				7: begin
					px = ox;
					py = 16'($urandom);
				end
				8: begin
					px = lpx;
					py = lpy;
				end
				9: begin
					// mirror of the previous candidate gives an equal distance
					px = (ox << 1) - lpx;
					py = (oy << 1) - lpy;
				end
				default: begin
					px = 16'($urandom);
					py = 16'($urandom);
				end
			endcase
			pres = !all_absent && ($urandom_range(0, 6) != 0);
			offer(ox, oy, px, py, pres, k == len - 1, 1'b0, '0);
			pace();
			lpx = px;
			lpy = py;
		end
	endtask

	// output side: scoring and backpressure
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_headings.size() == 0) begin
				$error("output transaction with no expected result: heading %0d found %0d",
					heading, found);
				mismatches++;
			end else begin
				head_result = expected_headings.pop_front();
				if (heading !== head_result.heading) begin
					$error("heading mismatch: expected %0d, actual %0d",
						head_result.heading, heading);
					mismatches++;
				end
				if (found !== head_result.found) begin
					$error("found mismatch: expected %0d, actual %0d",
						head_result.found, found);
					mismatches++;
				end
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= !out_stall;
				3: out_stall <= ($urandom_range(0, 9) != 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		observer_x = '0;
		observer_y = '0;
		point_x = '0;
		point_y = '0;
		point_present = 1'b0;
		last_point = 1'b0;
		clear_scan();
		directed_rows = '{
			'{16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b1, 16'sd0,  1'b0},
			'{16'd100,   16'd100,   16'd100,   16'd100,   1'b1, 1'b1, 1'b1, 16'sd0,  1'b1},
			'{16'd65535, 16'd0,     16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 16'sd0,  1'b1},
			'{16'd0,     16'd0,     16'd65535, 16'd0,     1'b1, 1'b1, 1'b1, HDG_PI,  1'b1},
			'{16'd0,     16'd65535, 16'd0,     16'd0,     1'b1, 1'b1, 1'b1, HDG_HALF_PI, 1'b1},
			'{16'd0,     16'd0,     16'd0,     16'd65535, 1'b1, 1'b1, 1'b1, -HDG_HALF_PI, 1'b1},
			'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1, 16'sd0,  1'b1},
			'{16'd65535, 16'd65535, 16'd0,     16'd0,     1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd0,     16'd65535, 16'd65535, 1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd65535, 16'd65535, 16'd0,     1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd65535, 16'd0,     16'd0,     16'd65535, 1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd200,   16'd300,   16'd0,     1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd0,     16'd300,   16'd200,   1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd500,   16'd500,   16'd490,   16'd490,   1'b1, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd500,   16'd500,   16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd500,   16'd500,   16'd510,   16'd490,   1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd1000,  16'd1000,  16'd0,     16'd0,     1'b1, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd1000,  16'd1000,  16'd990,   16'd1005,  1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd40000, 16'd20000, 16'd40001, 16'd19999, 1'b1, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd7,     16'd3,     16'd8,     16'd2,     1'b1, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd7,     16'd3,     16'd6,     16'd4,     1'b1, 1'b1, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 16'sd0,  1'b0},
			'{16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b1, 16'sd0,  1'b0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[r]) begin
			offer(directed_rows[r].ox, directed_rows[r].oy, directed_rows[r].px,
				directed_rows[r].py, directed_rows[r].pres, directed_rows[r].lst,
				directed_rows[r].typed,
				'{directed_rows[r].exp_heading, directed_rows[r].exp_found});
			pace();
		end
		drain_outputs();

		// long output hold while transactions keep coming
		hold_req = 1'b1;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS / 2)
			random_scan();
		drain_outputs();
		while (items_sent < RANDOM_ITEMS)
			random_scan();
		drain_outputs();
		repeat (CORDIC_ITERS + 20) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
